[rtl/ecd_pkg.sv]
// Shared types and constants for the epoch-seconds to civil date converter.
// Holds the stage control struct, calendar constants and reciprocal factors.
// No dependencies.
`timescale 1ns / 1ps

package ecd_pkg;

   localparam int EcdStages = 10;

   typedef struct packed {
      logic [EcdStages-1:0] load;
      logic [EcdStages-1:0] valid;
   } stage_ctrl_type;

   localparam logic signed [38:0] MinSeconds = -39'sd62135596800;
   localparam logic signed [38:0] MaxSeconds = 39'sd253402300799;
   localparam logic [38:0] EpochFromYear1 = 39'd62135596800;

   // 86400 = 675 * 2^7: the low seven bits of the count pass straight into the time of day.
   localparam int DayLowBits = 7;
   localparam logic [31:0] SecPerDayHigh = 32'd675;
   localparam int DayShift = 41;
   localparam logic [31:0] DayRecip = 32'(((64'd1 << DayShift) + 64'd674) / 64'd675);

   localparam logic [17:0] DaysPer400 = 18'd146097;
   localparam int Span400Shift = 40;
   localparam logic [22:0] Span400Recip =
      23'(((64'd1 << Span400Shift) + 64'd146096) / 64'd146097);

   localparam logic [17:0] DaysPer100 = 18'd36524;

   localparam logic [15:0] DaysPer4 = 16'd1461;
   localparam int Span4Shift = 30;
   localparam logic [19:0] Span4Recip = 20'(((64'd1 << Span4Shift) + 64'd1460) / 64'd1461);

   localparam logic [10:0] DaysPerYear = 11'd365;

   localparam logic [16:0] SecPerHour = 17'd3600;
   localparam int HourShift = 30;
   localparam logic [18:0] HourRecip = 19'(((64'd1 << HourShift) + 64'd3599) / 64'd3600);

   localparam logic [11:0] SecPerMin = 12'd60;
   localparam int MinuteShift = 20;
   localparam logic [14:0] MinuteRecip = 15'(((64'd1 << MinuteShift) + 64'd59) / 64'd60);

   localparam logic [8:0] MonthStart [13] = '{
      9'd0, 9'd31, 9'd59, 9'd90, 9'd120, 9'd151, 9'd181,
      9'd212, 9'd243, 9'd273, 9'd304, 9'd334, 9'd365
   };

endpackage

[rtl/ecd_pipe_ctrl.sv]
// Valid and load control for the converter pipeline.
// A stage loads when it is empty or when the stage after it moves on.
// Depends on ecd_pkg.
`timescale 1ns / 1ps

module ecd_pipe_ctrl
   import ecd_pkg::*;
(
   input  logic           clock,
   input  logic           reset,
   input  logic           req_valid,
   output logic           req_ready,
   input  logic           rsp_ready,
   output stage_ctrl_type ctrl
);

   logic [EcdStages-1:0] valid_ff;
   logic [EcdStages-1:0] valid_in;
   logic [EcdStages:0]   advance;

   always_comb begin
      advance[EcdStages] = rsp_ready;
      for (int k = EcdStages - 1; k >= 0; k--) begin
         advance[k] = !valid_ff[k] || advance[k+1];
      end
   end

   assign valid_in = {valid_ff[EcdStages-2:0], req_valid};

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= (valid_in & advance[EcdStages-1:0]) | (valid_ff & ~advance[EcdStages-1:0]);
      end
   end

   assign req_ready  = advance[0];
   assign ctrl.load  = advance[EcdStages-1:0];
   assign ctrl.valid = valid_ff;

endmodule

[rtl/epoch_seconds_to_civil_date.sv]
// Converter from signed seconds since 1970-01-01 00:00:00 to a Gregorian date and time.
// Ten register stages of constant-divisor arithmetic; control in ecd_pipe_ctrl.
// Depends on ecd_pkg and ecd_pipe_ctrl.
//
// Usage:
// A request carries one 39-bit signed count of seconds on req_epoch_seconds and is taken
// when req_valid and req_ready are both high. Each request gives exactly one response on
// the rsp_ channel: year, month, day of month, hour, minute and second, with
// rsp_out_of_range set and all other fields zero when the count lies outside years 1 to
// 9999. A response is taken when rsp_valid and rsp_ready are both high.
// A request passes through ten register stages before rsp_valid rises: the range check,
// the day split by reciprocal multiply and remainder, the 400-year, 100-year, 4-year and
// one-year splits, and the month lookup. One request can be taken in every cycle while the
// receiver takes the responses. When the receiver stalls, the stages fill up behind the
// output register and req_ready falls only when every stage holds a request; nothing is
// lost or repeated.
// Synchronous reset empties the pipeline; there is no other state.
`timescale 1ns / 1ps

module epoch_seconds_to_civil_date
   import ecd_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  logic signed [38:0] req_epoch_seconds,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic [13:0]        rsp_year,
   output logic [3:0]         rsp_month,
   output logic [4:0]         rsp_day_of_month,
   output logic [4:0]         rsp_hour,
   output logic [5:0]         rsp_minute,
   output logic [5:0]         rsp_second,
   output logic               rsp_out_of_range
);

   stage_ctrl_type ctrl;

   ecd_pipe_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_ready (rsp_ready),
      .ctrl      (ctrl)
   );

   // Stage 1: range check and move to a base of year 1.
   logic        s1_oor_ff, s1_oor_in;
   logic [38:0] s1_t_ff, s1_t_in;

   assign s1_oor_in = (req_epoch_seconds < MinSeconds) || (req_epoch_seconds > MaxSeconds);
   assign s1_t_in   = 39'(unsigned'(req_epoch_seconds) + EpochFromYear1);

   always_ff @(posedge clock) begin
      if (ctrl.load[0]) begin
         s1_oor_ff <= s1_oor_in;
         s1_t_ff   <= s1_t_in;
      end
   end

   // Stage 2: whole days by reciprocal.
   logic        s2_oor_ff;
   logic [38:0] s2_t_ff;
   logic [21:0] s2_qd_ff, s2_qd_in;
   logic [63:0] day_prod;

   assign day_prod = 64'(s1_t_ff[38:DayLowBits]) * 64'(DayRecip);
   assign s2_qd_in = day_prod[DayShift +: 22];

   always_ff @(posedge clock) begin
      if (ctrl.load[1]) begin
         s2_oor_ff <= s1_oor_ff;
         s2_t_ff   <= s1_t_ff;
         s2_qd_ff  <= s2_qd_in;
      end
   end

   // Stage 3: seconds of the day.
   logic        s3_oor_ff;
   logic [21:0] s3_days_ff;
   logic [16:0] s3_sod_ff, s3_sod_in;
   logic [31:0] day_rem;

   assign day_rem   = s2_t_ff[38:DayLowBits] - 32'(32'(s2_qd_ff) * SecPerDayHigh);
   assign s3_sod_in = {day_rem[9:0], s2_t_ff[DayLowBits-1:0]};

   always_ff @(posedge clock) begin
      if (ctrl.load[2]) begin
         s3_oor_ff  <= s2_oor_ff;
         s3_days_ff <= s2_qd_ff;
         s3_sod_ff  <= s3_sod_in;
      end
   end

   // Stage 4: 400-year spans and hour.
   logic        s4_oor_ff;
   logic [21:0] s4_days_ff;
   logic [16:0] s4_sod_ff;
   logic [4:0]  s4_q400_ff, s4_q400_in;
   logic [4:0]  s4_hour_ff, s4_hour_in;
   logic [44:0] q400_prod;
   logic [35:0] hour_prod;

   assign q400_prod  = 45'(s3_days_ff) * 45'(Span400Recip);
   assign s4_q400_in = q400_prod[Span400Shift +: 5];
   assign hour_prod  = 36'(s3_sod_ff) * 36'(HourRecip);
   assign s4_hour_in = hour_prod[HourShift +: 5];

   always_ff @(posedge clock) begin
      if (ctrl.load[3]) begin
         s4_oor_ff  <= s3_oor_ff;
         s4_days_ff <= s3_days_ff;
         s4_sod_ff  <= s3_sod_ff;
         s4_q400_ff <= s4_q400_in;
         s4_hour_ff <= s4_hour_in;
      end
   end

   // Stage 5: remainders after 400-year spans and after the hour.
   logic        s5_oor_ff;
   logic [4:0]  s5_q400_ff, s5_hour_ff;
   logic [17:0] s5_rem400_ff, s5_rem400_in;
   logic [11:0] s5_mrem_ff, s5_mrem_in;

   assign s5_rem400_in = 18'(s4_days_ff - 22'(22'(s4_q400_ff) * 22'(DaysPer400)));
   assign s5_mrem_in   = 12'(s4_sod_ff - 17'(17'(s4_hour_ff) * SecPerHour));

   always_ff @(posedge clock) begin
      if (ctrl.load[4]) begin
         s5_oor_ff    <= s4_oor_ff;
         s5_q400_ff   <= s4_q400_ff;
         s5_hour_ff   <= s4_hour_ff;
         s5_rem400_ff <= s5_rem400_in;
         s5_mrem_ff   <= s5_mrem_in;
      end
   end

   // Stage 6: 100-year spans, capped at three, and minute.
   logic        s6_oor_ff;
   logic [4:0]  s6_q400_ff, s6_hour_ff;
   logic [1:0]  s6_q100_ff, s6_q100_in;
   logic [15:0] s6_rem100_ff, s6_rem100_in;
   logic [11:0] s6_mrem_ff;
   logic [5:0]  s6_minute_ff, s6_minute_in;
   logic [26:0] minute_prod;

   assign s6_q100_in = 2'(s5_rem400_ff >= DaysPer100)
                     + 2'(s5_rem400_ff >= 18'(2 * DaysPer100))
                     + 2'(s5_rem400_ff >= 18'(3 * DaysPer100));
   assign s6_rem100_in = 16'(s5_rem400_ff - 18'(18'(s6_q100_in) * DaysPer100));
   assign minute_prod  = 27'(s5_mrem_ff) * 27'(MinuteRecip);
   assign s6_minute_in = minute_prod[MinuteShift +: 6];

   always_ff @(posedge clock) begin
      if (ctrl.load[5]) begin
         s6_oor_ff    <= s5_oor_ff;
         s6_q400_ff   <= s5_q400_ff;
         s6_hour_ff   <= s5_hour_ff;
         s6_mrem_ff   <= s5_mrem_ff;
         s6_q100_ff   <= s6_q100_in;
         s6_rem100_ff <= s6_rem100_in;
         s6_minute_ff <= s6_minute_in;
      end
   end

   // Stage 7: 4-year spans and second.
   logic        s7_oor_ff;
   logic [4:0]  s7_q400_ff, s7_hour_ff;
   logic [1:0]  s7_q100_ff;
   logic [15:0] s7_rem100_ff;
   logic [5:0]  s7_minute_ff;
   logic [4:0]  s7_q4_ff, s7_q4_in;
   logic [5:0]  s7_second_ff, s7_second_in;
   logic [35:0] q4_prod;

   assign q4_prod      = 36'(s6_rem100_ff) * 36'(Span4Recip);
   assign s7_q4_in     = q4_prod[Span4Shift +: 5];
   assign s7_second_in = 6'(s6_mrem_ff - 12'(12'(s6_minute_ff) * SecPerMin));

   always_ff @(posedge clock) begin
      if (ctrl.load[6]) begin
         s7_oor_ff    <= s6_oor_ff;
         s7_q400_ff   <= s6_q400_ff;
         s7_hour_ff   <= s6_hour_ff;
         s7_q100_ff   <= s6_q100_ff;
         s7_rem100_ff <= s6_rem100_ff;
         s7_minute_ff <= s6_minute_ff;
         s7_q4_ff     <= s7_q4_in;
         s7_second_ff <= s7_second_in;
      end
   end

   // Stage 8: days within the 4-year span.
   logic        s8_oor_ff;
   logic [4:0]  s8_q400_ff, s8_hour_ff, s8_q4_ff;
   logic [1:0]  s8_q100_ff;
   logic [5:0]  s8_minute_ff, s8_second_ff;
   logic [10:0] s8_rem4_ff, s8_rem4_in;

   assign s8_rem4_in = 11'(s7_rem100_ff - 16'(16'(s7_q4_ff) * DaysPer4));

   always_ff @(posedge clock) begin
      if (ctrl.load[7]) begin
         s8_oor_ff    <= s7_oor_ff;
         s8_q400_ff   <= s7_q400_ff;
         s8_hour_ff   <= s7_hour_ff;
         s8_q100_ff   <= s7_q100_ff;
         s8_q4_ff     <= s7_q4_ff;
         s8_minute_ff <= s7_minute_ff;
         s8_second_ff <= s7_second_ff;
         s8_rem4_ff   <= s8_rem4_in;
      end
   end

   // Stage 9: single years, capped at three, year number and leap flag.
   logic        s9_oor_ff;
   logic [4:0]  s9_hour_ff;
   logic [5:0]  s9_minute_ff, s9_second_ff;
   logic [13:0] s9_year_ff, s9_year_in;
   logic        s9_leap_ff, s9_leap_in;
   logic [8:0]  s9_yday_ff, s9_yday_in;
   logic [1:0]  q1;

   assign q1 = 2'(s8_rem4_ff >= DaysPerYear)
             + 2'(s8_rem4_ff >= 11'(2 * DaysPerYear))
             + 2'(s8_rem4_ff >= 11'(3 * DaysPerYear));
   assign s9_yday_in = 9'(s8_rem4_ff - 11'(11'(q1) * DaysPerYear));
   assign s9_year_in = 14'd1 + 14'(14'(s8_q400_ff) * 14'd400) + 14'(14'(s8_q100_ff) * 14'd100)
                     + 14'(14'(s8_q4_ff) * 14'd4) + 14'(q1);
   assign s9_leap_in = (q1 == 2'd3) && ((s8_q4_ff != 5'd24) || (s8_q100_ff == 2'd3));

   always_ff @(posedge clock) begin
      if (ctrl.load[8]) begin
         s9_oor_ff    <= s8_oor_ff;
         s9_hour_ff   <= s8_hour_ff;
         s9_minute_ff <= s8_minute_ff;
         s9_second_ff <= s8_second_ff;
         s9_year_ff   <= s9_year_in;
         s9_leap_ff   <= s9_leap_in;
         s9_yday_ff   <= s9_yday_in;
      end
   end

   // Stage 10: month and day of month, then the response register.
   logic [3:0]  month_sel;
   logic [9:0]  month_first;
   logic [4:0]  dom;
   logic [13:0] rsp_year_ff;
   logic [3:0]  rsp_month_ff;
   logic [4:0]  rsp_dom_ff, rsp_hour_ff;
   logic [5:0]  rsp_minute_ff, rsp_second_ff;
   logic        rsp_oor_ff;

   always_comb begin
      month_sel = 4'd12;
      for (int i = 12; i >= 1; i--) begin
         if (10'(s9_yday_ff) < 10'(MonthStart[i]) + 10'(s9_leap_ff && (i >= 2))) begin
            month_sel = 4'(i);
         end
      end
      month_first = 10'(MonthStart[month_sel - 4'd1]) + 10'(s9_leap_ff && (month_sel >= 4'd3));
      dom = 5'(10'(s9_yday_ff) - month_first + 10'd1);
   end

   always_ff @(posedge clock) begin
      if (ctrl.load[9]) begin
         rsp_oor_ff    <= s9_oor_ff;
         rsp_year_ff   <= s9_oor_ff ? '0 : s9_year_ff;
         rsp_month_ff  <= s9_oor_ff ? '0 : month_sel;
         rsp_dom_ff    <= s9_oor_ff ? '0 : dom;
         rsp_hour_ff   <= s9_oor_ff ? '0 : s9_hour_ff;
         rsp_minute_ff <= s9_oor_ff ? '0 : s9_minute_ff;
         rsp_second_ff <= s9_oor_ff ? '0 : s9_second_ff;
      end
   end

   assign rsp_valid        = ctrl.valid[EcdStages-1];
   assign rsp_year         = rsp_year_ff;
   assign rsp_month        = rsp_month_ff;
   assign rsp_day_of_month = rsp_dom_ff;
   assign rsp_hour         = rsp_hour_ff;
   assign rsp_minute       = rsp_minute_ff;
   assign rsp_second       = rsp_second_ff;
   assign rsp_out_of_range = rsp_oor_ff;

   a_oor_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_out_of_range |-> rsp_year == 14'd0 && rsp_month == 4'd0
         && rsp_day_of_month == 5'd0 && rsp_hour == 5'd0 && rsp_minute == 6'd0
         && rsp_second == 6'd0)
      else $error("out-of-range response carries nonzero fields");

   a_fields_legal: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_out_of_range |-> rsp_month >= 4'd1 && rsp_month <= 4'd12
         && rsp_day_of_month >= 5'd1 && rsp_hour < 5'd24 && rsp_minute < 6'd60
         && rsp_second < 6'd60 && rsp_year >= 14'd1 && rsp_year <= 14'd9999)
      else $error("response field outside its calendar range");

   a_stall_only_full: assert property (@(posedge clock) disable iff (reset)
      !req_ready |-> rsp_valid && !rsp_ready && (&ctrl.valid))
      else $error("request refused while the pipeline has room");

   a_resp_follows_req: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !$past(rsp_valid) && !$past(reset) |-> $past(ctrl.valid[EcdStages-2]))
      else $error("response appeared without a request in the stage before");

endmodule

[test/epoch_seconds_to_civil_date_tb.sv]
// Testbench for epoch_seconds_to_civil_date: directed calendar edges and random second counts.
// Expected dates come from a behavioral predictor inside this file; checks are in order.
// Depends only on the epoch_seconds_to_civil_date RTL and its package.
`timescale 1ns / 1ps

module epoch_seconds_to_civil_date_tb;

   localparam longint FirstSecond = -64'sd62135596800;
   localparam longint LastSecond = 64'sd253402300799;
   localparam longint Year1Offset = 64'sd62135596800;
   localparam longint SpanSeconds = 64'sd315537897600;
   localparam int CycleLimit = 100000;
   localparam int IdlePercent = 31;

   typedef struct packed {
      logic [13:0] year;
      logic [3:0]  month;
      logic [4:0]  day_of_month;
      logic [4:0]  hour;
      logic [5:0]  minute;
      logic [5:0]  second;
      logic        out_of_range;
   } civil_date_type;

   logic               clock;
   logic               reset;
   logic               req_valid;
   logic               req_ready;
   logic signed [38:0] req_epoch_seconds;
   logic               rsp_valid;
   logic               rsp_ready;
   logic [13:0]        rsp_year;
   logic [3:0]         rsp_month;
   logic [4:0]         rsp_day_of_month;
   logic [4:0]         rsp_hour;
   logic [5:0]         rsp_minute;
   logic [5:0]         rsp_second;
   logic               rsp_out_of_range;

   civil_date_type expected_dates [$];
   civil_date_type observed_date;
   civil_date_type wanted_date;
   int             error_count = 0;
   int             cycle_count = 0;
   bit             sender_idle_on = 1'b1;
   bit             receiver_idle_on = 1'b1;

   epoch_seconds_to_civil_date dut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_epoch_seconds (req_epoch_seconds),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_year          (rsp_year),
      .rsp_month         (rsp_month),
      .rsp_day_of_month  (rsp_day_of_month),
      .rsp_hour          (rsp_hour),
      .rsp_minute        (rsp_minute),
      .rsp_second        (rsp_second),
      .rsp_out_of_range  (rsp_out_of_range)
   );

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   function automatic longint days_before_month(input int month, input bit leap);
      longint first_day;
      case (month)
         1: first_day = 0;
         2: first_day = 31;
         3: first_day = 59;
         4: first_day = 90;
         5: first_day = 120;
         6: first_day = 151;
         7: first_day = 181;
         8: first_day = 212;
         9: first_day = 243;
         10: first_day = 273;
         11: first_day = 304;
         12: first_day = 334;
         default: first_day = 365;
      endcase
      if (leap && month >= 3) begin
         first_day = first_day + 1;
      end
      return first_day;
   endfunction

   function automatic civil_date_type civil_from_seconds(input logic signed [38:0] count);
      civil_date_type date;
      longint         secs;
      longint         days;
      longint         sod;
      longint         q400;
      longint         q100;
      longint         q4;
      longint         q1;
      longint         yday;
      bit             leap;
      int             month;
      date = '0;
      secs = count;
      if (secs < FirstSecond || secs > LastSecond) begin
         date.out_of_range = 1'b1;
         return date;
      end
      secs = secs + Year1Offset;
      days = secs / 86400;
      sod = secs % 86400;
      q400 = days / 146097;
      days = days % 146097;
      q100 = days / 36524;
      if (q100 > 3) begin
         q100 = 3;
      end
      days = days - q100 * 36524;
      q4 = days / 1461;
      days = days % 1461;
      q1 = days / 365;
      if (q1 > 3) begin
         q1 = 3;
      end
      yday = days - q1 * 365;
      leap = (q1 == 3) && (q4 != 24 || q100 == 3);
      month = 12;
      for (int m = 12; m >= 1; m--) begin
         if (yday < days_before_month(m + 1, leap)) begin
            month = m;
         end
      end
      date.year = 14'(1 + 400 * q400 + 100 * q100 + 4 * q4 + q1);
      date.month = 4'(month);
      date.day_of_month = 5'(yday - days_before_month(month, leap) + 1);
      date.hour = 5'(sod / 3600);
      date.minute = 6'((sod % 3600) / 60);
      date.second = 6'(sod % 60);
      return date;
   endfunction

   task automatic send_epoch_request(input longint count);
      @(negedge clock);
      while (sender_idle_on && $urandom_range(99) < IdlePercent) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid <= 1'b1;
      req_epoch_seconds <= count[38:0];
      @(posedge clock);
      while (!req_ready) begin
         @(posedge clock);
      end
      expected_dates.push_back(civil_from_seconds(count[38:0]));
   endtask

   task automatic wait_for_results();
      @(negedge clock);
      req_valid <= 1'b0;
      while (expected_dates.size() != 0) begin
         @(posedge clock);
      end
   endtask

   task automatic report_mismatch(input string what, input civil_date_type wanted,
                                  input civil_date_type seen);
      error_count++;
      if (error_count <= 10) begin
         $write("mismatch (%s): expected %0d-%0d-%0d %0d:%0d:%0d oor=%0b, ",
                what, wanted.year, wanted.month, wanted.day_of_month, wanted.hour,
                wanted.minute, wanted.second, wanted.out_of_range);
         $display("got %0d-%0d-%0d %0d:%0d:%0d oor=%0b",
                  seen.year, seen.month, seen.day_of_month, seen.hour, seen.minute,
                  seen.second, seen.out_of_range);
      end
   endtask

   always @(negedge clock) begin
      rsp_ready <= receiver_idle_on ? ($urandom_range(99) >= IdlePercent) : 1'b1;
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CycleLimit) begin
         $display("== FAIL ==");
         $finish;
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         observed_date.year = rsp_year;
         observed_date.month = rsp_month;
         observed_date.day_of_month = rsp_day_of_month;
         observed_date.hour = rsp_hour;
         observed_date.minute = rsp_minute;
         observed_date.second = rsp_second;
         observed_date.out_of_range = rsp_out_of_range;
         if (expected_dates.size() == 0) begin
            report_mismatch("unexpected response", '0, observed_date);
         end else begin
            wanted_date = expected_dates.pop_front();
            if (observed_date !== wanted_date) begin
               report_mismatch("field", wanted_date, observed_date);
            end
         end
      end
   end

   task automatic test_calendar_edges();
      longint directed_counts [22];
      directed_counts = '{
         FirstSecond, FirstSecond - 1, LastSecond, LastSecond + 1,
         -64'sd274877906944, 64'sd274877906943, 0, -1, 1, 86399, 86400, -86400, -86401,
         64'sd951782400, 64'sd951868800, -64'sd2203891201, -64'sd2203891200,
         64'sd4133980799, 64'sd1709210096, -64'sd11676096000, 64'sd1104451200,
         64'sd978307199
      };
      foreach (directed_counts[i]) begin
         send_epoch_request(directed_counts[i]);
      end
   endtask

   task automatic test_uniform_dates(input int count);
      longint unsigned draw;
      for (int i = 0; i < count; i++) begin
         draw = {$urandom(), $urandom()};
         send_epoch_request(longint'(draw % SpanSeconds) - Year1Offset);
      end
   endtask

   // Day counts land on or near the first and last days of 400, 100, 4 and 1 year spans and around the end of February.
   task automatic test_span_boundaries(input int count);
      longint days;
      longint sod;
      for (int i = 0; i < count; i++) begin
         days = 146097 * $urandom_range(24) + 36524 * $urandom_range(3)
              + 1461 * $urandom_range(24) + 365 * $urandom_range(3);
         case ($urandom_range(7))
            0: days = days + 0;
            1: days = days + 1;
            2: days = days + 58;
            3: days = days + 59;
            4: days = days + 60;
            5: days = days + 364;
            6: days = days + 365;
            default: days = days - 1;
         endcase
         case ($urandom_range(2))
            0: sod = 0;
            1: sod = 86399;
            default: sod = $urandom_range(86399);
         endcase
         send_epoch_request(days * 86400 + sod - Year1Offset);
      end
   endtask

   task automatic test_full_width_counts(input int count);
      logic [38:0] raw;
      for (int i = 0; i < count; i++) begin
         case ($urandom_range(3))
            0: send_epoch_request(FirstSecond - $urandom_range(100000));
            1: send_epoch_request(LastSecond + $urandom_range(100000));
            default: begin
               raw = 39'({$urandom(), $urandom()});
               send_epoch_request(longint'($signed(raw)));
            end
         endcase
      end
   endtask

   task automatic test_back_to_back(input int count);
      sender_idle_on = 1'b0;
      receiver_idle_on = 1'b0;
      test_uniform_dates(count / 2);
      test_span_boundaries(count / 2);
      wait_for_results();
      sender_idle_on = 1'b1;
      receiver_idle_on = 1'b1;
   endtask

   initial begin
      reset = 1'b1;
      req_valid = 1'b0;
      req_epoch_seconds = '0;
      rsp_ready = 1'b0;
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      test_calendar_edges();
      wait_for_results();
      test_uniform_dates(500);
      test_span_boundaries(450);
      test_back_to_back(300);
      test_full_width_counts(250);

      wait_for_results();
      repeat (20) @(posedge clock);
      if (error_count == 0 && expected_dates.size() == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end

endmodule

[sim.f]
rtl/ecd_pkg.sv
rtl/ecd_pipe_ctrl.sv
rtl/epoch_seconds_to_civil_date.sv
test/epoch_seconds_to_civil_date_tb.sv
